// File: rtl/hatt_pkg.sv
// ----------------------------------------------------------------------------
// hatt_pkg
// Shared types and constants for the Hilbert axes-to-transpose pipeline.
// ----------------------------------------------------------------------------
package hatt_pkg;

  localparam int DIMENSIONS = 9;
  localparam int COORD_BITS = 16;
  localparam int ORDER_W    = 5;
  localparam int LEVEL_W    = $clog2(COORD_BITS);
  localparam int NUM_CELLS  = COORD_BITS - 1;

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(COORD_BITS);

  typedef logic [COORD_BITS-1:0] word_t;
  typedef word_t [DIMENSIONS-1:0] vec_t;
  typedef logic [ORDER_W-1:0] order_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic [15:0] coord_0;
    logic [15:0] coord_1;
    logic [15:0] coord_2;
    logic [15:0] coord_3;
    logic [15:0] coord_4;
    logic [15:0] coord_5;
    logic [15:0] coord_6;
    logic [15:0] coord_7;
    logic [15:0] coord_8;
  } in_item_t;

  typedef struct packed {
    logic [15:0] index_word_0;
    logic [15:0] index_word_1;
    logic [15:0] index_word_2;
    logic [15:0] index_word_3;
    logic [15:0] index_word_4;
    logic [15:0] index_word_5;
    logic [15:0] index_word_6;
    logic [15:0] index_word_7;
    logic [15:0] index_word_8;
  } out_item_t;

endpackage

// File: rtl/hatt_cell.sv
// ----------------------------------------------------------------------------
// hatt_cell
// One bit level of the excess-work pass: walks all axes at its level when
// that level is below the curve order, and registers the point for the next cell.
// ----------------------------------------------------------------------------
module hatt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  hatt_pkg::level_t  cell_level,
  input  hatt_pkg::order_t  eff_order,
  input  logic              up_valid,
  input  hatt_pkg::vec_t    up_data,
  output logic              up_stall,
  output logic              dn_valid,
  output hatt_pkg::vec_t    dn_data,
  input  logic              dn_stall
);

  logic           valid_r;
  hatt_pkg::vec_t data_r;
  hatt_pkg::vec_t data_nxt;
  hatt_pkg::word_t low_mask;
  hatt_pkg::word_t diff;
  logic           active;

  // Invert or exchange the low bits of each axis against axis 0
  always_comb begin
    low_mask = hatt_pkg::word_t'((hatt_pkg::word_t'(1) << cell_level)
                                 - hatt_pkg::word_t'(1));
    active   = (hatt_pkg::ORDER_W'(cell_level) < eff_order);
    data_nxt = up_data;
    diff     = '0;
    if (active) begin
      for (int i = 0; i < hatt_pkg::DIMENSIONS; i++) begin
        if (data_nxt[i][cell_level]) begin
          data_nxt[0] = data_nxt[0] ^ low_mask;
        end else begin
          diff        = (data_nxt[0] ^ data_nxt[i]) & low_mask;
          data_nxt[0] = data_nxt[0] ^ diff;
          data_nxt[i] = data_nxt[i] ^ diff;
        end
      end
    end
  end

  // Hold while the downstream beat is stalled
  assign up_stall = valid_r && dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: rtl/hatt_gray.sv
// ----------------------------------------------------------------------------
// hatt_gray
// Gray decode stage: prefix XOR over the axes, then the order-limited mask
// from the last word; registers the result beat.
// ----------------------------------------------------------------------------
module hatt_gray (
  input  logic               clk,
  input  logic               rst_n,
  input  hatt_pkg::order_t   eff_order,
  input  logic               up_valid,
  input  hatt_pkg::vec_t     up_data,
  output logic               up_stall,
  output logic               dn_valid,
  output hatt_pkg::vec_t     dn_data,
  input  logic               dn_stall
);

  logic            valid_r;
  hatt_pkg::vec_t  data_r;
  hatt_pkg::vec_t  data_nxt;
  hatt_pkg::vec_t  prefix;
  hatt_pkg::word_t tmask;
  logic            acc;

  // Prefix XOR, then fold the set bits of the last word into the mask
  always_comb begin
    prefix = up_data;
    for (int i = 1; i < hatt_pkg::DIMENSIONS; i++) begin
      prefix[i] = prefix[i] ^ prefix[i-1];
    end
    acc   = 1'b0;
    tmask = '0;
    for (int j = hatt_pkg::COORD_BITS - 1; j >= 0; j--) begin
      tmask[j] = acc;
      if (hatt_pkg::ORDER_W'(j) < eff_order) begin
        acc = acc ^ prefix[hatt_pkg::DIMENSIONS-1][j];
      end
    end
    for (int i = 0; i < hatt_pkg::DIMENSIONS; i++) begin
      data_nxt[i] = prefix[i] ^ tmask;
    end
  end

  // Hold while the result beat is stalled
  assign up_stall = valid_r && dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: rtl/hilbert_axes_to_transpose_9d.sv
// ----------------------------------------------------------------------------
// hilbert_axes_to_transpose_9d
// Maps a nine-axis point to its transposed Hilbert index with a row of
// per-bit-level cells followed by a Gray decode stage.
// ----------------------------------------------------------------------------
//
//   channel  | ports                             | beat
//   ---------+-----------------------------------+-----------------------------
//   input    | in_valid, in_stall, in_data       | nine 16-bit coordinates
//   result   | out_valid, out_stall, out_data    | nine 16-bit index words
//   config   | cfg_we, cfg_wdata                 | curve order, 5 bits
//
// One point enters per cycle while in_stall is low; each result passes 15 cells,
// one per bit level from 15 down to 1, then the decode stage.
// Cells at or above the curve order pass the point through unchanged.
// Reset clears all stage valids and sets the curve order to 16.
// A stall holds only stages that hold a beat; empty stages keep filling.
// ----------------------------------------------------------------------------
module hilbert_axes_to_transpose_9d (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hatt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hatt_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  hatt_pkg::order_t    cfg_wdata
);

  hatt_pkg::order_t order_r;
  hatt_pkg::order_t eff_order;

  logic           chain_valid [hatt_pkg::NUM_CELLS+1];
  logic           chain_stall [hatt_pkg::NUM_CELLS+1];
  hatt_pkg::vec_t chain_data  [hatt_pkg::NUM_CELLS+1];
  hatt_pkg::vec_t result;

  // Curve order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= hatt_pkg::ORDER_RESET;
    end else if (cfg_we) begin
      order_r <= cfg_wdata;
    end
  end

  // Clamp the order to 1..COORD_BITS
  always_comb begin
    if (order_r == '0) begin
      eff_order = hatt_pkg::order_t'(1);
    end else if (order_r > hatt_pkg::order_t'(hatt_pkg::COORD_BITS)) begin
      eff_order = hatt_pkg::order_t'(hatt_pkg::COORD_BITS);
    end else begin
      eff_order = order_r;
    end
  end

  // Feed the input beat into the first cell
  assign chain_valid[0]   = in_valid;
  assign chain_data[0][0] = in_data.coord_0;
  assign chain_data[0][1] = in_data.coord_1;
  assign chain_data[0][2] = in_data.coord_2;
  assign chain_data[0][3] = in_data.coord_3;
  assign chain_data[0][4] = in_data.coord_4;
  assign chain_data[0][5] = in_data.coord_5;
  assign chain_data[0][6] = in_data.coord_6;
  assign chain_data[0][7] = in_data.coord_7;
  assign chain_data[0][8] = in_data.coord_8;
  assign in_stall         = chain_stall[0];

  // Row of cells, top bit level first
  for (genvar k = 0; k < hatt_pkg::NUM_CELLS; k++) begin : g_cell
    hatt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_level (hatt_pkg::level_t'(hatt_pkg::COORD_BITS - 1 - k)),
      .eff_order  (eff_order),
      .up_valid   (chain_valid[k]),
      .up_data    (chain_data[k]),
      .up_stall   (chain_stall[k]),
      .dn_valid   (chain_valid[k+1]),
      .dn_data    (chain_data[k+1]),
      .dn_stall   (chain_stall[k+1])
    );
  end

  // Gray decode and result register
  hatt_gray u_gray (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_order (eff_order),
    .up_valid  (chain_valid[hatt_pkg::NUM_CELLS]),
    .up_data   (chain_data[hatt_pkg::NUM_CELLS]),
    .up_stall  (chain_stall[hatt_pkg::NUM_CELLS]),
    .dn_valid  (out_valid),
    .dn_data   (result),
    .dn_stall  (out_stall)
  );

  assign out_data.index_word_0 = result[0];
  assign out_data.index_word_1 = result[1];
  assign out_data.index_word_2 = result[2];
  assign out_data.index_word_3 = result[3];
  assign out_data.index_word_4 = result[4];
  assign out_data.index_word_5 = result[5];
  assign out_data.index_word_6 = result[6];
  assign out_data.index_word_7 = result[7];
  assign out_data.index_word_8 = result[8];

endmodule
